@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ hw/rtl/tdc_pkg.sv @@
// Types, constants and controller interface of the track duplicate classifier.
// No dependencies.
`timescale 1ns / 1ps

package tdc_pkg;

  localparam int MAX_TRACKS_DEF = 32;
  localparam logic [15:0] SCORE_CUT_RESET = 16'd32768;

  localparam logic [1:0] CAT_UNIQUE = 2'd0;
  localparam logic [1:0] CAT_DUP    = 2'd1;
  localparam logic [1:0] CAT_FAKE   = 2'd2;

  typedef struct packed {
    logic [15:0] track_id;
    logic [15:0] match_score;
    logic        is_last;
  } item_t;

  typedef struct packed {
    logic [15:0] out_track_id;
    logic [15:0] out_score;
    logic [1:0]  category;
    logic        overflow;
    logic        last_result;
  } result_t;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] score;
  } trk_t;

  typedef struct packed {
    logic accept;
    logic key_rd;
    logic key_cap;
    logic scan;
    logic sort_wr;
    logic cls_eval;
    logic cls_fix;
    logic emit;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic i_last;
    logic j_end;
    logic fix;
  } status_t;

endpackage

@@ hw/rtl/tdc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tdc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/tdc_ctrl.sv @@
// Sequencer for load, sort, classify and report phases.
// Depends on tdc_pkg for the command and status structs.
`timescale 1ns / 1ps

module tdc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             is_last,
  input  tdc_pkg::status_t status,
  output tdc_pkg::cmd_t    cmd,
  output logic             busy
);

  import tdc_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_KEY   = 10'b0000000010,
    S_KCAP  = 10'b0000000100,
    S_SCAN  = 10'b0000001000,
    S_SWR   = 10'b0000010000,
    S_CRD   = 10'b0000100000,
    S_CEVAL = 10'b0001000000,
    S_CFIX  = 10'b0010000000,
    S_ORD   = 10'b0100000000,
    S_OEMIT = 10'b1000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        cmd.accept = start;
        if (start && is_last) begin
          state_next = S_KEY;
        end
      end
      S_KEY: begin
        cmd.key_rd = 1'b1;
        state_next = S_KCAP;
      end
      S_KCAP: begin
        cmd.key_cap = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.j_end) begin
          state_next = S_SWR;
        end
      end
      S_SWR: begin
        cmd.sort_wr = 1'b1;
        cmd.advance = 1'b1;
        state_next = status.i_last ? S_CRD : S_KEY;
      end
      S_CRD: begin
        state_next = S_CEVAL;
      end
      S_CEVAL: begin
        cmd.cls_eval = 1'b1;
        if (status.fix) begin
          state_next = S_CFIX;
        end else begin
          cmd.advance = 1'b1;
          state_next = status.i_last ? S_ORD : S_CRD;
        end
      end
      S_CFIX: begin
        cmd.cls_fix = 1'b1;
        cmd.advance = 1'b1;
        state_next = status.i_last ? S_ORD : S_CRD;
      end
      S_ORD: begin
        state_next = S_OEMIT;
      end
      S_OEMIT: begin
        cmd.emit = 1'b1;
        cmd.advance = 1'b1;
        state_next = status.i_last ? S_IDLE : S_ORD;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

@@ hw/rtl/tdc_datapath.sv @@
// Track stores, rank counter, class logic and result register.
// Depends on tdc_pkg and tdc_ram.
`timescale 1ns / 1ps

module tdc_datapath #(
  parameter int MAX_TRACKS = tdc_pkg::MAX_TRACKS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  tdc_pkg::cmd_t    cmd,
  output tdc_pkg::status_t status,
  input  tdc_pkg::item_t   item,
  input  logic             cut_we,
  input  logic [15:0]      cut_data,
  output tdc_pkg::result_t result,
  output logic             result_valid
);

  import tdc_pkg::*;

  localparam int IDX_W = $clog2(MAX_TRACKS);
  localparam int CNT_W = $clog2(MAX_TRACKS + 1);
  localparam int TRK_W = $bits(trk_t);

  logic [15:0]      score_cut;
  logic [CNT_W-1:0] count;
  logic             ovf;
  logic [CNT_W-1:0] i;
  logic [CNT_W-1:0] j;
  logic [IDX_W-1:0] rank;
  trk_t             key;
  logic             have_u;
  logic [IDX_W-1:0] uniq_idx;
  logic [15:0]      uniq_id;
  logic [15:0]      uniq_score;

  trk_t             raw_wdata, raw_rdata, srt_rdata;
  logic [IDX_W-1:0] raw_raddr;
  logic             raw_we;
  logic [1:0]       cls_rdata, cls_wdata, eval_cat;
  logic [IDX_W-1:0] cls_waddr;
  logic [CNT_W-1:0] jd;
  logic             less, fake, new_u, better, full;

  assign full      = (count == CNT_W'(MAX_TRACKS));
  assign raw_we    = cmd.accept && !full;
  assign raw_wdata = '{id: item.track_id, score: item.match_score};
  assign raw_raddr = cmd.key_rd ? i[IDX_W-1:0] : j[IDX_W-1:0];

  tdc_ram #(.WIDTH(TRK_W), .DEPTH(MAX_TRACKS)) u_raw (
    .clk   (clk),
    .we    (raw_we),
    .waddr (count[IDX_W-1:0]),
    .wdata (raw_wdata),
    .raddr (raw_raddr),
    .rdata (raw_rdata)
  );

  tdc_ram #(.WIDTH(TRK_W), .DEPTH(MAX_TRACKS)) u_sorted (
    .clk   (clk),
    .we    (cmd.sort_wr),
    .waddr (rank),
    .wdata (key),
    .raddr (i[IDX_W-1:0]),
    .rdata (srt_rdata)
  );

  tdc_ram #(.WIDTH(2), .DEPTH(MAX_TRACKS)) u_class (
    .clk   (clk),
    .we    (cmd.cls_eval || cmd.cls_fix),
    .waddr (cls_waddr),
    .wdata (cls_wdata),
    .raddr (i[IDX_W-1:0]),
    .rdata (cls_rdata)
  );

  assign jd   = j - CNT_W'(1);
  assign less = (raw_rdata.id < key.id) || ((raw_rdata.id == key.id) && (jd < i));

  assign fake   = (srt_rdata.score < score_cut);
  assign new_u  = !have_u || (srt_rdata.id != uniq_id);
  assign better = (srt_rdata.score > uniq_score);

  always_comb begin
    if (fake) begin
      eval_cat = CAT_FAKE;
    end else if (new_u || better) begin
      eval_cat = CAT_UNIQUE;
    end else begin
      eval_cat = CAT_DUP;
    end
  end

  assign cls_waddr = cmd.cls_fix ? uniq_idx : i[IDX_W-1:0];
  assign cls_wdata = cmd.cls_fix ? CAT_DUP : eval_cat;

  assign status.i_last = ((i + CNT_W'(1)) == count);
  assign status.j_end  = (j == count);
  assign status.fix    = !fake && !new_u && better;

  always_ff @(posedge clk) begin
    if (rst) begin
      score_cut    <= SCORE_CUT_RESET;
      count        <= '0;
      ovf          <= 1'b0;
      i            <= '0;
      have_u       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cut_we) begin
        score_cut <= cut_data;
      end
      if (cmd.accept) begin
        i      <= '0;
        have_u <= 1'b0;
        if (full) begin
          ovf <= 1'b1;
        end else begin
          count <= count + CNT_W'(1);
        end
      end
      if (cmd.advance) begin
        i <= status.i_last ? '0 : i + CNT_W'(1);
      end
      if (cmd.cls_eval && !fake && new_u) begin
        have_u <= 1'b1;
      end
      result_valid <= cmd.emit;
      if (cmd.emit && status.i_last) begin
        count <= '0;
        ovf   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.key_rd) begin
      j <= '0;
    end
    if (cmd.key_cap) begin
      key  <= raw_rdata;
      rank <= '0;
      j    <= j + CNT_W'(1);
    end
    if (cmd.scan) begin
      rank <= rank + IDX_W'(less);
      j    <= j + CNT_W'(1);
    end
    if (cmd.cls_eval && !fake && (new_u || better)) begin
      uniq_id    <= srt_rdata.id;
      uniq_score <= srt_rdata.score;
      if (new_u) begin
        uniq_idx <= i[IDX_W-1:0];
      end
    end
    if (cmd.cls_fix) begin
      uniq_idx <= i[IDX_W-1:0];
    end
    if (cmd.emit) begin
      result <= '{out_track_id: srt_rdata.id,
                  out_score:    srt_rdata.score,
                  category:     cls_rdata,
                  overflow:     ovf,
                  last_result:  status.i_last};
    end
  end

endmodule

@@ hw/rtl/track_duplicate_classifier.sv @@
// Track duplicate classifier top level: controller plus datapath.
// Depends on tdc_pkg, tdc_ctrl, tdc_datapath and assert_macros.svh.
// Flow: tracks are accepted while idle; after the last track, each stored track is ranked
// by scanning the raw store through its one read port and written to the sorted store,
// then each track is classified, then the results are emitted one at a time. No new track
// is accepted until the last result is out. Results cannot be stalled.
// Reset (synchronous): clears the event, the overflow flag, and sets the cut to 0.5.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module track_duplicate_classifier #(
  parameter int MAX_TRACKS = tdc_pkg::MAX_TRACKS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  tdc_pkg::item_t   item,
  input  logic             cut_we,
  input  logic [15:0]      cut_data,
  output tdc_pkg::result_t result,
  output logic             result_valid
);

  import tdc_pkg::*;

  cmd_t    cmd;
  status_t status;

  tdc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .is_last (item.is_last),
    .status  (status),
    .cmd     (cmd),
    .busy    (busy)
  );

  tdc_datapath #(.MAX_TRACKS(MAX_TRACKS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .item         (item),
    .cut_we       (cut_we),
    .cut_data     (cut_data),
    .result       (result),
    .result_valid (result_valid)
  );

  `ASSERT_NXT(a_last_goes_busy, clk, rst, start && !busy && item.is_last, busy)
  `ASSERT_NXT(a_strobe_spaced, clk, rst, result_valid, !result_valid)
  `ASSERT_IMP(a_more_pending, clk, rst, result_valid && !result.last_result, busy)

endmodule
